/* hdl/urif_pkg.sv */
// Shared types and constants for the unique random index filter.
// Used by the controller, the datapath and the top level; depends on nothing else.
package urif_pkg;

    localparam int WORD_W      = 30;  // random candidate word
    localparam int SIZE_W      = 17;  // size register and emitted count
    localparam int INDEX_W     = 16;  // index and position fields
    localparam int ROW_W       = 32;  // seen-map bits held in one memory row
    localparam int ROW_BIT_W   = 5;   // bit select within a row
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 32;
    localparam int DIV_CNT_W   = 5;   // counts the remainder steps

    localparam logic [SIZE_W-1:0]    SIZE_RESET   = 17'd65536;
    localparam logic [SIZE_W-1:0]    INDEX_LIMIT  = 17'd65536;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST_CNT = 5'd29;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // latch the word and the effective size
        logic div_step;   // one restoring remainder step
        logic mem_rd;     // read the seen-map row of the index
        logic emit;       // mark the index, load the output, bump the count
        logic clr_step;   // clear one seen-map row
        logic clr_count;  // zero the emitted count
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic complete;   // every index of the current size has been emitted
        logic div_last;   // the current remainder step is the final one
        logic clr_last;   // the current clearing row is the final one
        logic seen;       // the index is already marked in the map
        logic out_free;   // the output register can take a result this cycle
    } sts_t;

endpackage

/* hdl/urif_ctrl.sv */
// Controller state machine for the unique random index filter.
// Depends on urif_pkg for the command and status structs.
module urif_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    input  logic           s_restart,
    input  urif_pkg::sts_t sts,
    output logic           s_tready,
    output urif_pkg::cmd_t cmd
);
    import urif_pkg::*;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_DIV   = 5'b00100,
        ST_READ  = 5'b01000,
        ST_CHECK = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_restart) begin
                        cmd.clr_count = 1'b1;
                        state_next    = ST_CLEAR;
                    end else if (!sts.complete) begin
                        cmd.load   = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.mem_rd = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                // A repeated index is dropped; a new one waits for a free output.
                if (sts.seen) begin
                    state_next = ST_IDLE;
                end else if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

/* hdl/urif_datapath.sv */
// Datapath of the unique random index filter: size register, remainder unit,
// seen-map memory, emitted count and output register. Depends on urif_pkg.
module urif_datapath #(
    parameter int MAX_ENTRIES = 65536
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [urif_pkg::SIZE_W-1:0]          cfg_wdata,
    input  logic [urif_pkg::WORD_W-1:0]          s_word,
    input  urif_pkg::cmd_t                       cmd,
    output urif_pkg::sts_t                       sts,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [urif_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                 m_tlast
);
    import urif_pkg::*;

    localparam int CAP_INT  = (MAX_ENTRIES < int'(INDEX_LIMIT)) ? MAX_ENTRIES
                                                                : int'(INDEX_LIMIT);
    localparam int ROWS_MIN = (CAP_INT + ROW_W - 1) / ROW_W;
    localparam int ROW_AW   = (ROWS_MIN > 1) ? $clog2(ROWS_MIN) : 1;
    localparam int ROWS     = 2 ** ROW_AW;
    localparam logic [SIZE_W-1:0] CAP = SIZE_W'(CAP_INT);

    logic [SIZE_W-1:0]    size_reg;
    logic [SIZE_W-1:0]    eff_size;
    logic [SIZE_W-1:0]    count_reg;
    logic [SIZE_W-1:0]    count_next;
    logic [SIZE_W-1:0]    div_reg;
    logic [SIZE_W-1:0]    rem_reg;
    logic [WORD_W-1:0]    word_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [SIZE_W:0]      trial;
    logic [SIZE_W:0]      diff;
    logic [INDEX_W-1:0]   idx;
    logic [ROW_AW-1:0]    row_sel;
    logic [ROW_BIT_W-1:0] bit_sel;
    logic [ROW_W-1:0]     bit_mask;
    logic [ROW_W-1:0]     rd_data_reg;
    logic [ROW_AW-1:0]    clr_addr_reg;
    logic [ROW_W-1:0]     map_mem [0:ROWS-1];
    logic                 out_valid_reg;
    logic [INDEX_W-1:0]   out_index_reg;
    logic [INDEX_W-1:0]   out_pos_reg;
    logic                 out_last_reg;

    // A size of zero counts as one; sizes beyond the map are saturated.
    always_comb begin
        if (size_reg == '0) begin
            eff_size = SIZE_W'(1);
        end else if (size_reg > CAP) begin
            eff_size = CAP;
        end else begin
            eff_size = size_reg;
        end
    end

    assign count_next = count_reg + SIZE_W'(1);

    // Restoring remainder step: the partial remainder stays below the divisor.
    assign trial = {rem_reg, word_reg[WORD_W-1]};
    assign diff  = trial - {1'b0, div_reg};

    assign idx      = rem_reg[INDEX_W-1:0];
    assign row_sel  = idx[ROW_BIT_W +: ROW_AW];
    assign bit_sel  = idx[ROW_BIT_W-1:0];
    assign bit_mask = ROW_W'(1) << bit_sel;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= SIZE_RESET;
        end else if (cfg_we) begin
            size_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.clr_count) begin
            count_reg <= '0;
        end else if (cmd.emit) begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            word_reg    <= s_word;
            div_reg     <= eff_size;
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end else if (cmd.div_step) begin
            word_reg    <= word_reg << 1;
            rem_reg     <= diff[SIZE_W] ? trial[SIZE_W-1:0] : diff[SIZE_W-1:0];
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_addr_reg <= clr_addr_reg + ROW_AW'(1);
        end
    end

    // Seen map: one write port shared by clearing and marking, one read port.
    always_ff @(posedge aclk) begin
        if (cmd.clr_step) begin
            map_mem[clr_addr_reg] <= '0;
        end else if (cmd.emit) begin
            map_mem[row_sel] <= rd_data_reg | bit_mask;
        end
        if (cmd.mem_rd) begin
            rd_data_reg <= map_mem[row_sel];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_index_reg <= idx;
            out_pos_reg   <= count_reg[INDEX_W-1:0];
            out_last_reg  <= (count_next == div_reg);
        end
    end

    assign sts.complete = (count_reg >= eff_size);
    assign sts.div_last = (div_cnt_reg == DIV_LAST_CNT);
    assign sts.clr_last = (clr_addr_reg == {ROW_AW{1'b1}});
    assign sts.seen     = rd_data_reg[bit_sel];
    assign sts.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_pos_reg, out_index_reg};
    assign m_tlast  = out_last_reg;

endmodule

/* hdl/unique_random_index_filter_top.sv */
// From acceptance to m_tvalid a word goes through 30 one-bit remainder steps, one seen-map
// row read, one check and mark; more while an earlier result waits in the output register.
// The block takes no new candidate word until it is through with the last one.
// A restart request clears the map row by row, ceil(min(MAX_ENTRIES, 65536) / 32) rows rounded
// up to a power of two of at least two (2048 at the default); the same pass follows aresetn,
// with s_tready low throughout, and the size register resets to 65536.
module unique_random_index_filter_top #(
    parameter int MAX_ENTRIES = 65536
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [urif_pkg::SIZE_W-1:0]         cfg_wdata,   // size_in_use
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [urif_pkg::IN_TDATA_W-1:0]     s_tdata,     // [29:0] random_word
    input  logic [0:0]                          s_tuser,     // [0] restart
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [urif_pkg::OUT_TDATA_W-1:0]    m_tdata,     // [15:0] index, [31:16] position
    output logic                                m_tlast      // last
);
    import urif_pkg::*;

    cmd_t cmd;
    sts_t sts;

    urif_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_restart (s_tuser[0]),
        .sts       (sts),
        .s_tready  (s_tready),
        .cmd       (cmd)
    );

    urif_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_word    (s_tdata[WORD_W-1:0]),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // A restart request starts the clearing pass, which holds off further requests.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser[0]) |=> !s_tready)
        else $error("restart request did not start the clearing pass");

    // A candidate word on an unfinished permutation keeps the block busy.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !s_tuser[0] && !sts.complete) |=> !s_tready)
        else $error("candidate request did not start the remainder unit");

    // A result is only produced into a free output register, and it then shows.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (sts.out_free && !sts.seen) ##1 m_tvalid)
        else $error("result emitted into a busy output or not presented");

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for unique_random_index_filter_top: drives candidate words and
// restarts, rewrites the size register between phases and checks every drawn index.
// Depends only on the RTL (urif_pkg and the top level).
module tb_top;

    localparam int MAX_ENTRIES   = 65536;
    localparam int SIZE_CAP      = (MAX_ENTRIES < 65536) ? MAX_ENTRIES : 65536;
    localparam int RANDOM_ITEMS  = 500;
    localparam int DRAIN_WAIT    = 40;    // a little over one word's latency
    localparam int CLEAR_WAIT    = 2100;  // the seen-map clearing pass plus a margin
    localparam int HOLD_CYCLES   = 600;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [15:0] index;
        logic [15:0] position;
        logic        last;
    } draw_t;

    // Tracks the permutation in progress and the draws still owed by the block.
    class permutation_scoreboard;
        bit [MAX_ENTRIES-1:0] seen_map;
        logic [16:0]          drawn_count;
        logic [16:0]          size_reg;
        draw_t                expected_draws[$];
        int                   failures;

        function new();
            seen_map    = '0;
            drawn_count = '0;
            size_reg    = 17'd65536;
            failures    = 0;
        endfunction

        function void set_size(logic [16:0] value);
            size_reg = value;
        endfunction

        function logic [16:0] effective_size();
            logic [16:0] s;
            s = size_reg;
            if (s == 17'd0)
                s = 17'd1;
            if (s > SIZE_CAP)
                s = 17'(SIZE_CAP);
            return s;
        endfunction

        function int pending();
            return expected_draws.size();
        endfunction

        // Notes an accepted request and queues the draw that it owes, if any.
        function void note_request(logic [29:0] word, logic restart);
            logic [16:0] s;
            logic [29:0] idx;
            draw_t       d;
            if (restart) begin
                seen_map    = '0;
                drawn_count = '0;
                return;
            end
            s = effective_size();
            if (drawn_count >= s)
                return;
            idx = word % s;
            if (seen_map[idx])
                return;
            seen_map[idx] = 1'b1;
            d.index       = idx[15:0];
            d.position    = drawn_count[15:0];
            drawn_count   = drawn_count + 17'd1;
            d.last        = (drawn_count == s);
            expected_draws.push_back(d);
        endfunction

        function void flag_mismatch(string what, draw_t want, draw_t got);
            string want_text;
            string got_text;
            failures++;
            if (failures <= REPORT_LIMIT) begin
                want_text = $sformatf("expected index %0d position %0d last %0b",
                                      want.index, want.position, want.last);
                got_text  = $sformatf("got index %0d position %0d last %0b",
                                      got.index, got.position, got.last);
                $display("mismatch (%s): %s, %s", what, want_text, got_text);
            end
        endfunction

        function void check_result(logic [31:0] data, logic last);
            draw_t want;
            draw_t got;
            got.index    = data[15:0];
            got.position = data[31:16];
            got.last     = last;
            want         = '0;
            if (expected_draws.size() == 0) begin
                flag_mismatch("no result expected", want, got);
                return;
            end
            want = expected_draws.pop_front();
            if (got !== want)
                flag_mismatch("wrong field", want, got);
        endfunction
    endclass

    logic                              aclk = 1'b0;
    logic                              aresetn;
    logic                              cfg_we;
    logic [urif_pkg::SIZE_W-1:0]       cfg_wdata;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [urif_pkg::IN_TDATA_W-1:0]   s_tdata;
    logic [0:0]                        s_tuser;
    logic                              m_tvalid;
    logic                              m_tready;
    logic [urif_pkg::OUT_TDATA_W-1:0]  m_tdata;
    logic                              m_tlast;

    permutation_scoreboard sb = new();

    int burst_left   = 0;
    bit gaps_on      = 1'b1;
    bit restart_tail = 1'b0;
    int hold_asked   = 0;

    unique_random_index_filter_top #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tlast);
    end

    // Offers one request, in bursts with random gaps, and notes it once it is taken.
    task automatic offer_request(input logic [29:0] word, input logic restart);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            if (gaps_on) begin
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 45)
                                                  : $urandom_range(0, 4);
                if (gap > 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, word};
        s_tuser  <= restart;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(word, restart);
        restart_tail = restart;
    endtask

    task automatic wait_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    // A word that is rejected gives nothing to wait for, so the tail covers its latency.
    task automatic settle_block();
        wait_results();
        repeat (restart_tail ? CLEAR_WAIT : DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_size(input logic [16:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        sb.set_size(value);
    endtask

    function automatic logic [16:0] pick_size();
        int r;
        r = $urandom_range(0, 19);
        if (r < 13)
            return 17'($urandom_range(1, 24));
        if (r < 16)
            return 17'($urandom_range(25, 300));
        case (r)
            16:      return 17'd0;
            17:      return 17'h1FFFF;
            18:      return 17'd65535;
            default: return 17'd65536;
        endcase
    endfunction

    // Receiver stall pattern: segments of differing readiness, plus long hold-offs on request.
    initial begin : stall_pattern
        int   seg_left;
        int   seg_mode;
        int   hold_left;
        int   hold_served;
        logic ready;
        seg_left    = 0;
        seg_mode    = 0;
        hold_left   = 0;
        hold_served = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_asked != hold_served) begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end
            if (seg_left == 0) begin
                seg_mode = $urandom_range(0, 3);
                seg_left = $urandom_range(16, 300);
            end
            seg_left--;
            if (hold_left > 0) begin
                hold_left--;
                ready = 1'b0;
            end else begin
                case (seg_mode)
                    0:       ready = 1'b1;
                    1:       ready = 1'($urandom_range(0, 1));
                    2:       ready = ($urandom_range(0, 3) == 0);
                    default: ready = ($urandom_range(0, 7) != 0);
                endcase
            end
            m_tready <= ready;
        end
    end

    initial begin
        #4_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin : stimulus
        int          counted;
        int          phase;
        int          n;
        int          k;
        logic [16:0] s;
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Full size out of reset: extreme words, repeats of an index and a restart.
        offer_request(30'd0, 1'b0);
        offer_request(30'h3FFF_FFFF, 1'b0);
        offer_request(30'd65535, 1'b0);
        offer_request(30'd65536, 1'b0);
        offer_request(30'h2AAA_AAAA, 1'b0);
        offer_request(30'h1555_5555, 1'b0);
        offer_request(30'h3FFF_FFFF, 1'b1);
        offer_request(30'd0, 1'b0);

        // A size of zero behaves as one, so a single draw completes the permutation.
        settle_block();
        write_size(17'd0);
        offer_request(30'h1555_5555, 1'b1);
        offer_request(30'd123, 1'b0);
        offer_request(30'd7, 1'b0);

        // An oversized value saturates; growing the size reopens the permutation.
        settle_block();
        write_size(17'h1FFFF);
        offer_request(30'd1, 1'b0);

        // Shrinking below the count leaves the block complete.
        settle_block();
        write_size(17'd1);
        offer_request(30'd9, 1'b0);

        settle_block();
        write_size(17'd4);
        offer_request(30'd5, 1'b0);
        offer_request(30'd6, 1'b0);
        offer_request(30'd7, 1'b0);

        settle_block();
        write_size(17'd65535);
        offer_request(30'd65534, 1'b0);
        offer_request(30'h3FFF_FFFF, 1'b0);

        settle_block();
        write_size(17'd2);
        offer_request(30'd0, 1'b0);
        offer_request(30'd0, 1'b1);
        offer_request(30'd1, 1'b0);
        offer_request(30'd0, 1'b0);
        offer_request(30'd3, 1'b0);

        counted = 0;
        phase   = 0;
        while (counted < RANDOM_ITEMS) begin
            settle_block();
            if (phase == 0 || $urandom_range(0, 4) != 0)
                write_size(pick_size());
            gaps_on = ($urandom_range(0, 2) != 0);
            s = sb.effective_size();
            if (s <= 300)
                n = (s * 4 + 8 > 120) ? 120 : s * 4 + 8;
            else
                n = $urandom_range(15, 40);
            if ($urandom_range(0, 9) < 7) begin
                offer_request(30'($urandom), 1'b1);
                counted++;
            end
            for (k = 0; k < n; k++) begin
                // The sender keeps offering while the receiver holds off, so the block backs up.
                if (k == 5 && (phase == 0 || $urandom_range(0, 7) == 0))
                    hold_asked++;
                if (k == n / 2 && (phase == 1 || $urandom_range(0, 3) == 0))
                    wait_results();
                offer_request(30'($urandom), ($urandom_range(0, 24) == 0));
                counted++;
            end
            phase++;
        end

        settle_block();
        if (sb.failures == 0 && sb.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
